>>> rtl/seconds_offset_to_calendar_date_macros.svh
// ----------------------------------------------------------------------------
// seconds offset to calendar date: assertion macros
// concurrent checks sampled on the rising clock edge, masked during reset
// ----------------------------------------------------------------------------
`ifndef SECONDS_OFFSET_TO_CALENDAR_DATE_MACROS_SVH
`define SECONDS_OFFSET_TO_CALENDAR_DATE_MACROS_SVH

// same-cycle implication
`define SOCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("socd same-cycle check failed");

// next-cycle implication
`define SOCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("socd next-cycle check failed");

`endif

>>> rtl/socd_pkg.sv
// ----------------------------------------------------------------------------
// socd_pkg
// shared types, constants and the month length function for the date converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package socd_pkg;

  // field and datapath widths
  localparam int unsigned OFFSET_W  = 32;
  localparam int unsigned DAYS_W    = 17;
  localparam int unsigned DIVISOR_W = 6;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // time unit constants
  localparam logic [5:0] SECS_PER_MIN  = 6'd60;
  localparam logic [5:0] MINS_PER_HOUR = 6'd60;
  localparam logic [5:0] HOURS_PER_DAY = 6'd24;
  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

  // month numbers: January and the short months
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;

  // month lengths and two-digit leap rule
  localparam logic [7:0] LEAP_MASK     = 8'h03;
  localparam logic [4:0] MLEN_FEB      = 5'h1C;
  localparam logic [4:0] MLEN_FEB_LEAP = 5'h1D;
  localparam logic [4:0] MLEN_SHORT    = 5'h1E;
  localparam logic [4:0] MLEN_LONG     = 5'h1F;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_YEAR,
    REG_MONTH,
    REG_DAY,
    REG_HOUR,
    REG_MINUTE,
    REG_SECOND
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CARRY,
    ST_WALK,
    ST_HOLD
  } state_t;

  // which constant division is running
  typedef enum logic [1:0] {
    DS_SEC,
    DS_MIN,
    DS_HOUR
  } div_stage_t;

  // divider control and status
  typedef struct packed {
    logic                 start;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIVISOR_W-1:0] rem;
  } div_rsp_t;

  // days in a month; out-of-range months count as long months
  function automatic logic [4:0] month_length(input logic [3:0] month,
                                              input logic [7:0] year);
    logic       leap;
    logic [4:0] len;
    leap = ((year & LEAP_MASK) == 8'd0) && (year != 8'd0);
    priority if (month == MON_FEB) begin
      len = leap ? MLEN_FEB_LEAP : MLEN_FEB;
    end else if (month == MON_APR || month == MON_JUN ||
                 month == MON_SEP || month == MON_NOV) begin
      len = MLEN_SHORT;
    end else begin
      len = MLEN_LONG;
    end
    return len;
  endfunction

endpackage

>>> rtl/socd_if.sv
// ----------------------------------------------------------------------------
// socd_in_if / socd_out_if
// valid/ready channels carrying the seconds offset and the calendar result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface socd_in_if;
  logic                            valid;
  logic                            ready;
  logic [socd_pkg::OFFSET_W-1:0]   offset_seconds;

  modport source (output valid, output offset_seconds, input ready);
  modport sink   (input valid, input offset_seconds, output ready);
endinterface

interface socd_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] out_second;
  logic [5:0] out_minute;
  logic [4:0] out_hour;
  logic [4:0] out_day;
  logic [3:0] out_month;
  logic [7:0] out_year;

  modport source (output valid, output out_second, output out_minute, output out_hour,
                  output out_day, output out_month, output out_year, input ready);
  modport sink   (input valid, input out_second, input out_minute, input out_hour,
                  input out_day, input out_month, input out_year, output ready);
endinterface

>>> rtl/socd_cdiv.sv
// ----------------------------------------------------------------------------
// socd_cdiv
// divider by 60 or 24 through reciprocal multiplication
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module socd_cdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  socd_pkg::div_req_t            req,
  input  logic [socd_pkg::OFFSET_W-1:0] dividend,
  output logic [socd_pkg::OFFSET_W-1:0] quotient,
  output socd_pkg::div_rsp_t            rsp
);
  import socd_pkg::*;

  localparam int unsigned PROD_W = 2 * OFFSET_W;

  // 60 = 4 * 15 and 24 = 8 * 3: drop the power of two, then multiply by the
  // rounded-up reciprocal of the odd factor, exact for any 32-bit dividend
  localparam logic [OFFSET_W-1:0] RECIP_15 = 32'h8888_8889;
  localparam logic [OFFSET_W-1:0] RECIP_3  = 32'hAAAA_AAAB;
  localparam int unsigned         POST_15  = 35;
  localparam int unsigned         POST_3   = 33;

  logic [OFFSET_W-1:0]    num_r;
  logic [OFFSET_W-1:0]    quo_r;
  logic [DIVISOR_W-1:0]   rem_r;
  logic [DIVISOR_W-1:0]   divisor_r;
  logic                   mul_r;
  logic                   sub_r;
  logic                   done_r;

  logic                   by_day;
  logic [OFFSET_W-1:0]    scaled;
  logic [OFFSET_W-1:0]    recip;
  logic [PROD_W-1:0]      prod;
  logic [OFFSET_W-1:0]    quo_nxt;
  logic [2*DIVISOR_W-1:0] back;
  logic [DIVISOR_W-1:0]   rem_nxt;

  // quotient: pre-shift, multiply by the reciprocal, keep the high bits
  always_comb begin
    by_day  = (divisor_r == HOURS_PER_DAY);
    scaled  = by_day ? (num_r >> 3) : (num_r >> 2);
    recip   = by_day ? RECIP_3 : RECIP_15;
    prod    = PROD_W'(scaled) * PROD_W'(recip);
    quo_nxt = by_day ? OFFSET_W'(prod >> POST_3) : OFFSET_W'(prod >> POST_15);
  end

  // remainder is below 64, so the low bits of dividend minus q*d suffice
  always_comb begin
    back    = {{DIVISOR_W{1'b0}}, quo_r[DIVISOR_W-1:0]} * {{DIVISOR_W{1'b0}}, divisor_r};
    rem_nxt = num_r[DIVISOR_W-1:0] - back[DIVISOR_W-1:0];
  end

  // step sequence: multiply, remainder, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= req.start;
      sub_r  <= mul_r;
      done_r <= sub_r;
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r     <= dividend;
      divisor_r <= req.divisor;
    end
    if (mul_r) begin
      quo_r <= quo_nxt;
    end
    if (sub_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

>>> rtl/seconds_offset_to_calendar_date.sv
// ----------------------------------------------------------------------------
// seconds_offset_to_calendar_date
// adds a seconds offset to a programmed reference date and time
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transfer carries a 32-bit seconds offset
//   out_ch : one transfer carries second, minute, hour, day, month, year
//   cfg_*  : APB-style port holding the reference year, month, day, hour,
//            minute and second at byte addresses 0x00 to 0x14
// One item at a time. The offset goes through a shared reciprocal-multiply
// divider three times (by 60, by 60, by 24), then a carry step, then a walk
// step for each month boundary crossed and a last one when the walk stops
// inside a month. in_ch.ready is high only while the block is idle, so the
// next offset is taken in the cycle after the result transfer at the
// earliest. The result stays in its output registers until out_ch takes it;
// a stalled receiver holds the block busy. Reset returns the sequencer to
// idle, drops any result in flight and restores the reference date to year
// 0, January 1, 00:00:00.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seconds_offset_to_calendar_date (
  input  logic                            clk,
  input  logic                            rst_n,
  socd_in_if.sink                         in_ch,
  socd_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [socd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [socd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [socd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import socd_pkg::*;

`include "seconds_offset_to_calendar_date_macros.svh"

  // reference registers
  logic [6:0] ref_year_r;
  logic [3:0] ref_month_r;
  logic [4:0] ref_day_r;
  logic [4:0] ref_hour_r;
  logic [5:0] ref_minute_r;
  logic [5:0] ref_second_r;

  // sequencer
  state_t     state_r, state_nxt;
  div_stage_t stage_r, stage_nxt;

  // working registers
  logic [5:0]        rsec_r;
  logic [5:0]        rmin_r;
  logic [4:0]        rhour_r;
  logic [DAYS_W-1:0] days_r;
  logic [5:0]        sec_r;
  logic [5:0]        min_r;
  logic [4:0]        hour_r;
  logic [4:0]        day_r;
  logic [3:0]        month_r;
  logic [7:0]        year_r;

  // divider hookup
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [OFFSET_W-1:0] div_dividend;
  logic [OFFSET_W-1:0] div_quo;

  logic     in_xfer;
  logic     out_xfer;
  logic     cfg_wr;
  cfg_reg_t cfg_idx;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  socd_cdiv u_cdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .quotient (div_quo),
    .rsp      (div_rsp)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_year_r   <= 7'd0;
      ref_month_r  <= MON_JAN;
      ref_day_r    <= 5'd1;
      ref_hour_r   <= 5'd0;
      ref_minute_r <= 6'd0;
      ref_second_r <= 6'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_YEAR:   ref_year_r   <= cfg_pwdata[6:0];
        REG_MONTH:  ref_month_r  <= cfg_pwdata[3:0];
        REG_DAY:    ref_day_r    <= cfg_pwdata[4:0];
        REG_HOUR:   ref_hour_r   <= cfg_pwdata[4:0];
        REG_MINUTE: ref_minute_r <= cfg_pwdata[5:0];
        REG_SECOND: ref_second_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_YEAR:   cfg_prdata = CFG_DATA_W'(ref_year_r);
      REG_MONTH:  cfg_prdata = CFG_DATA_W'(ref_month_r);
      REG_DAY:    cfg_prdata = CFG_DATA_W'(ref_day_r);
      REG_HOUR:   cfg_prdata = CFG_DATA_W'(ref_hour_r);
      REG_MINUTE: cfg_prdata = CFG_DATA_W'(ref_minute_r);
      REG_SECOND: cfg_prdata = CFG_DATA_W'(ref_second_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // carry ripple from seconds into the day count
  logic [6:0] s_sum, s_fix, m_sum, m_fix;
  logic [5:0] h_sum, h_fix;
  logic       s_c, m_c, h_c;

  always_comb begin
    s_sum = {1'b0, rsec_r} + {1'b0, ref_second_r};
    s_c   = s_sum >= 7'(SECS_PER_MIN);
    s_fix = s_c ? s_sum - 7'(SECS_PER_MIN) : s_sum;
    m_sum = {1'b0, rmin_r} + {1'b0, ref_minute_r} + 7'(s_c);
    m_c   = m_sum >= 7'(MINS_PER_HOUR);
    m_fix = m_c ? m_sum - 7'(MINS_PER_HOUR) : m_sum;
    h_sum = {1'b0, rhour_r} + {1'b0, ref_hour_r} + 6'(m_c);
    h_c   = h_sum >= HOURS_PER_DAY;
    h_fix = h_c ? h_sum - HOURS_PER_DAY : h_sum;
  end

  // one month of the day walk
  logic [4:0] mlen;
  logic [5:0] span;
  logic [5:0] excess;
  logic       past_end;
  logic       leaves_month;

  always_comb begin
    mlen         = month_length(month_r, year_r);
    span         = {1'b0, mlen} - {1'b0, day_r} + 6'd1;
    excess       = {1'b0, day_r} - {1'b0, mlen} - 6'd1;
    past_end     = {1'b0, day_r} > ({1'b0, mlen} + 6'd1);
    leaves_month = past_end || (days_r >= DAYS_W'(span));
  end

  // sequencer next state and divider control
  always_comb begin
    state_nxt        = state_r;
    stage_nxt        = stage_r;
    div_req.start    = 1'b0;
    div_req.divisor  = SECS_PER_MIN;
    div_dividend     = div_quo;
    unique case (state_r)
      ST_IDLE: begin
        div_dividend = in_ch.offset_seconds;
        if (in_xfer) begin
          div_req.start = 1'b1;
          stage_nxt     = DS_SEC;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          unique case (stage_r)
            DS_SEC: begin
              div_req.start   = 1'b1;
              div_req.divisor = MINS_PER_HOUR;
              stage_nxt       = DS_MIN;
            end
            DS_MIN: begin
              div_req.start   = 1'b1;
              div_req.divisor = HOURS_PER_DAY;
              stage_nxt       = DS_HOUR;
            end
            default: begin
              state_nxt = ST_CARRY;
            end
          endcase
        end
      end
      ST_CARRY: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (days_r == '0) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_xfer) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stage_r <= DS_SEC;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_DIV: begin
        if (div_rsp.done) begin
          unique case (stage_r)
            DS_SEC: rsec_r <= div_rsp.rem;
            DS_MIN: rmin_r <= div_rsp.rem;
            default: begin
              rhour_r <= div_rsp.rem[4:0];
              days_r  <= div_quo[DAYS_W-1:0];
            end
          endcase
        end
      end
      ST_CARRY: begin
        sec_r   <= s_fix[5:0];
        min_r   <= m_fix[5:0];
        hour_r  <= h_fix[4:0];
        days_r  <= days_r + DAYS_W'(h_c);
        year_r  <= {1'b0, ref_year_r};
        month_r <= ref_month_r;
        day_r   <= ref_day_r;
      end
      ST_WALK: begin
        if (days_r != '0) begin
          if (leaves_month) begin
            if (past_end) begin
              days_r <= days_r + DAYS_W'(excess);
            end else begin
              days_r <= days_r - DAYS_W'(span);
            end
            if (month_r >= MONTHS_PER_YEAR) begin
              month_r <= MON_JAN;
              year_r  <= year_r + 8'd1;
            end else begin
              month_r <= month_r + 4'd1;
            end
            day_r <= 5'd1;
          end else begin
            day_r  <= day_r + days_r[4:0];
            days_r <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // result channel
  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = (state_r == ST_HOLD);
  assign out_ch.out_second = sec_r;
  assign out_ch.out_minute = min_r;
  assign out_ch.out_hour   = hour_r;
  assign out_ch.out_day    = day_r;
  assign out_ch.out_month  = month_r;
  assign out_ch.out_year   = year_r;

  // checks
  `SOCD_ASSERT_SAME(a_no_accept_while_result, clk, rst_n, out_ch.valid, !in_ch.ready)
  `SOCD_ASSERT_NEXT(a_accept_starts_div, clk, rst_n, in_xfer, state_r == ST_DIV)
  `SOCD_ASSERT_SAME(a_div_done_in_div, clk, rst_n, div_rsp.done, state_r == ST_DIV)
  `SOCD_ASSERT_NEXT(a_walk_end_shows, clk, rst_n, state_r == ST_WALK && days_r == '0, out_ch.valid)

endmodule
